// ===== hdl/sfd_pkg.sv =====
// sfd_pkg: payload structs, status and kind codes, and the internal select
// types shared by the sensor frame decoder and its scaling pipeline.
// No dependencies.
package sfd_pkg;

  typedef struct packed {
    logic [7:0] frame_byte0;
    logic [7:0] frame_byte1;
    logic [7:0] frame_byte2;
    logic [7:0] frame_byte3;
  } frame_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [3:0]        sensor_kind;
    logic [2:0]        switch_number;
    logic signed [15:0] converted_value;
    logic              load_request;
    logic [2:0]        load_target;
    logic [2:0]        load_event;
  } result_t;

  typedef enum logic [1:0] {
    STATUS_OK           = 2'd0,
    STATUS_BAD_CHECKSUM = 2'd1,
    STATUS_WRONG_DEVICE = 2'd2,
    STATUS_UNKNOWN_KIND = 2'd3
  } status_t;

  localparam logic [3:0] KIND_TEMPERATURE = 4'd0;
  localparam logic [3:0] KIND_HUMIDITY    = 4'd1;
  localparam logic [3:0] KIND_LIGHT       = 4'd2;
  localparam logic [3:0] KIND_PIR         = 4'd3;
  localparam logic [3:0] KIND_TOUCH       = 4'd4;

  localparam logic [2:0] DEV_TYPE_RESET = 3'd1;
  localparam logic [2:0] EVT_NO_LOAD    = 3'd3;

  // millivolt scale numerator; the denominator 1000 is folded into the divisors
  localparam logic [11:0] MV_SCALE = 12'd3226;
  localparam int unsigned PROD_W = 22;

  // which conversion the scaling pipeline applies
  typedef enum logic [2:0] {
    CONV_ZERO  = 3'd0,
    CONV_TEMP  = 3'd1,
    CONV_HUM   = 3'd2,
    CONV_LIGHT = 3'd3,
    CONV_PIR   = 3'd4
  } conv_sel_t;

  typedef struct packed {
    status_t    status;
    logic [3:0] kind;
    logic [2:0] sw;
    logic       req;
    logic [2:0] target;
    logic [2:0] evt;
  } side_t;

endpackage

// ===== hdl/sfd_scaler.sv =====
// sfd_scaler: four-stage conversion of the scaled raw product into
// Fahrenheit, humidity, light or the PIR bit, with truncating division.
// Depends on sfd_pkg.
module sfd_scaler (
  input  logic                           clk,
  input  logic                           en,
  input  sfd_pkg::conv_sel_t             sel,
  input  logic [sfd_pkg::PROD_W-1:0]     prod,
  input  logic                           pir,
  output logic signed [15:0]             value
);

  localparam logic [21:0] TEMP_OFFSET  = 22'd500000;
  localparam logic [21:0] HUM_OFFSET   = 22'd750000;
  localparam logic [14:0] DIV_TEMP     = 15'd10000;
  localparam logic [14:0] DIV_HUM      = 15'd30000;
  localparam logic [14:0] DIV_LIGHT    = 15'd125;
  // floor(2^37 / divisor); the estimate is at most one low
  localparam logic [30:0] RECIP_TEMP   = 31'd13743895;
  localparam logic [30:0] RECIP_HUM    = 31'd4581298;
  localparam logic [30:0] RECIP_LIGHT  = 31'd1099511627;
  localparam int unsigned RECIP_SHIFT  = 37;
  // ceil(2^16 / 5), exact for the Fahrenheit numerator range
  localparam logic [13:0] FIVE_RECIP   = 14'd13108;
  localparam logic [12:0] F_OFFSET     = 13'd160;

  function automatic logic [30:0] recip_of(sfd_pkg::conv_sel_t s);
    case (s)
      sfd_pkg::CONV_TEMP: recip_of = RECIP_TEMP;
      sfd_pkg::CONV_HUM:  recip_of = RECIP_HUM;
      default:            recip_of = RECIP_LIGHT;
    endcase
  endfunction

  function automatic logic [14:0] div_of(sfd_pkg::conv_sel_t s);
    case (s)
      sfd_pkg::CONV_TEMP: div_of = DIV_TEMP;
      sfd_pkg::CONV_HUM:  div_of = DIV_HUM;
      default:            div_of = DIV_LIGHT;
    endcase
  endfunction

  // stage 2: offset and magnitude
  logic [21:0]        mag_next;
  logic               neg_next;
  logic [21:0]        s2_mag;
  logic               s2_neg;
  sfd_pkg::conv_sel_t s2_sel;
  logic               s2_pir;

  always_comb begin
    mag_next = prod;
    neg_next = 1'b0;
    case (sel)
      sfd_pkg::CONV_TEMP: begin
        if (prod >= TEMP_OFFSET) begin
          mag_next = prod - TEMP_OFFSET;
        end else begin
          mag_next = TEMP_OFFSET - prod;
          neg_next = 1'b1;
        end
      end
      sfd_pkg::CONV_HUM: begin
        if (prod >= HUM_OFFSET) begin
          mag_next = prod - HUM_OFFSET;
        end else begin
          mag_next = HUM_OFFSET - prod;
          neg_next = 1'b1;
        end
      end
      default: begin
        mag_next = prod;
        neg_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_mag <= mag_next;
      s2_neg <= neg_next;
      s2_sel <= sel;
      s2_pir <= pir;
    end
  end

  // stage 3: reciprocal multiply, quotient estimate
  logic [52:0]        full;
  logic [14:0]        s3_q;
  logic [21:0]        s3_mag;
  logic               s3_neg;
  sfd_pkg::conv_sel_t s3_sel;
  logic               s3_pir;

  assign full = {31'b0, s2_mag} * {22'b0, recip_of(s2_sel)};

  always_ff @(posedge clk) begin
    if (en) begin
      s3_q   <= full[RECIP_SHIFT+14:RECIP_SHIFT];
      s3_mag <= s2_mag;
      s3_neg <= s2_neg;
      s3_sel <= s2_sel;
      s3_pir <= s2_pir;
    end
  end

  // stage 4: remainder check, one correction step
  logic [21:0]        qd;
  logic [21:0]        rem;
  logic [14:0]        q_next;
  logic [14:0]        s4_q;
  logic               s4_neg;
  sfd_pkg::conv_sel_t s4_sel;
  logic               s4_pir;

  assign qd     = {7'b0, s3_q} * {7'b0, div_of(s3_sel)};
  assign rem    = s3_mag - qd;
  assign q_next = (rem >= {7'b0, div_of(s3_sel)}) ? s3_q + 15'd1 : s3_q;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_q   <= q_next;
      s4_neg <= s3_neg;
      s4_sel <= s3_sel;
      s4_pir <= s3_pir;
    end
  end

  // stage 5: signed quotient and Fahrenheit numerator 9*C + 160
  logic [12:0]        nine_q;
  logic [12:0]        xmag_next;
  logic               xneg_next;
  logic [15:0]        qz;
  logic [11:0]        s5_xmag;
  logic               s5_xneg;
  logic [15:0]        s5_qs;
  sfd_pkg::conv_sel_t s5_sel;
  logic               s5_pir;

  assign nine_q = (13'(s4_q[8:0]) << 3) + 13'(s4_q[8:0]);
  assign qz     = {1'b0, s4_q};

  always_comb begin
    if (!s4_neg) begin
      xmag_next = F_OFFSET + nine_q;
      xneg_next = 1'b0;
    end else if (nine_q > F_OFFSET) begin
      xmag_next = nine_q - F_OFFSET;
      xneg_next = 1'b1;
    end else begin
      xmag_next = F_OFFSET - nine_q;
      xneg_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_xmag <= xmag_next[11:0];
      s5_xneg <= xneg_next;
      s5_qs   <= s4_neg ? (~qz + 16'd1) : qz;
      s5_sel  <= s4_sel;
      s5_pir  <= s4_pir;
    end
  end

  // output side: divide by five and pick the reading
  logic [25:0] f_full;
  logic [15:0] fz;
  logic [15:0] temp_val;

  assign f_full   = {14'b0, s5_xmag} * {12'b0, FIVE_RECIP};
  assign fz       = {6'b0, f_full[25:16]};
  assign temp_val = s5_xneg ? (~fz + 16'd1) : fz;

  always_comb begin
    case (s5_sel)
      sfd_pkg::CONV_TEMP:  value = $signed(temp_val);
      sfd_pkg::CONV_HUM:   value = $signed(s5_qs);
      sfd_pkg::CONV_LIGHT: value = $signed(s5_qs);
      sfd_pkg::CONV_PIR:   value = $signed({15'b0, s5_pir});
      default:             value = 16'sd0;
    endcase
  end

endmodule

// ===== hdl/sensor_frame_decoder.sv =====
// sensor_frame_decoder: checks and decodes 4-byte sensor frames into readings.
// Depends on sfd_pkg and sfd_scaler.
//
//   channel  | signals                        | payload
//   ---------+--------------------------------+-------------------------
//   frame    | frame_valid, frame_stall       | sfd_pkg::frame_t
//   result   | result_valid, result_stall     | sfd_pkg::result_t
//   cfg      | cfg_valid, cfg_ready           | cfg_data (device type)
//
// one frame per cycle while frame_stall is low; each result passes through the product register
// and the divide path: offset, reciprocal multiply, remainder correction, Fahrenheit step
// and the output register.
// rst is synchronous; it clears the valid bits and sets the device type to 1.
// a stalled result freezes the whole pipeline, so frame_stall follows it.
module sensor_frame_decoder (
  input  logic             clk,
  input  logic             rst,
  input  logic             frame_valid,
  output logic             frame_stall,
  input  sfd_pkg::frame_t  frame,
  output logic             result_valid,
  input  logic             result_stall,
  output sfd_pkg::result_t result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_data
);

  logic [2:0] dev_type;
  logic       adv;

  assign cfg_ready   = 1'b1;
  assign adv         = !(result_valid && result_stall);
  assign frame_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      dev_type <= sfd_pkg::DEV_TYPE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      dev_type <= cfg_data;
    end
  end

  // stage 1 decode
  logic [7:0]         x;
  logic [3:0]         nib;
  logic [3:0]         kind;
  logic [9:0]         raw;
  sfd_pkg::status_t   status_next;
  sfd_pkg::conv_sel_t sel_next;
  sfd_pkg::side_t     side_next;

  assign x    = frame.frame_byte0 ^ frame.frame_byte1 ^ frame.frame_byte2 ^ frame.frame_byte3;
  assign nib  = x[7:4] ^ x[3:0];
  assign kind = {frame.frame_byte0[1:0], frame.frame_byte1[7:6]};
  assign raw  = {frame.frame_byte1[5:0], frame.frame_byte2[7:4]};

  always_comb begin
    if (nib != 4'd0) begin
      status_next = sfd_pkg::STATUS_BAD_CHECKSUM;
    end else if (frame.frame_byte0[7:5] != dev_type) begin
      status_next = sfd_pkg::STATUS_WRONG_DEVICE;
    end else if (kind > sfd_pkg::KIND_TOUCH) begin
      status_next = sfd_pkg::STATUS_UNKNOWN_KIND;
    end else begin
      status_next = sfd_pkg::STATUS_OK;
    end
  end

  always_comb begin
    side_next.status = status_next;
    side_next.kind   = kind;
    side_next.sw     = frame.frame_byte0[4:2];
    side_next.req    = 1'b0;
    side_next.target = 3'd0;
    side_next.evt    = 3'd0;
    sel_next         = sfd_pkg::CONV_ZERO;
    if (status_next == sfd_pkg::STATUS_OK) begin
      case (kind)
        sfd_pkg::KIND_TEMPERATURE: sel_next = sfd_pkg::CONV_TEMP;
        sfd_pkg::KIND_HUMIDITY:    sel_next = sfd_pkg::CONV_HUM;
        sfd_pkg::KIND_LIGHT:       sel_next = sfd_pkg::CONV_LIGHT;
        sfd_pkg::KIND_PIR:         sel_next = sfd_pkg::CONV_PIR;
        default: begin
          side_next.target = raw[9:7];
          side_next.evt    = raw[6:4];
          side_next.req    = (raw[6:4] != sfd_pkg::EVT_NO_LOAD);
        end
      endcase
    end
  end

  logic [sfd_pkg::PROD_W-1:0] s1_prod;
  sfd_pkg::conv_sel_t         s1_sel;
  logic                       s1_pir;
  sfd_pkg::side_t             side_pipe [5];
  logic [4:0]                 vld;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_prod      <= {12'b0, raw} * {10'b0, sfd_pkg::MV_SCALE};
      s1_sel       <= sel_next;
      s1_pir       <= frame.frame_byte1[0];
      side_pipe[0] <= side_next;
      for (int i = 1; i < 5; i++) begin
        side_pipe[i] <= side_pipe[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld          <= '0;
      result_valid <= 1'b0;
    end else if (adv) begin
      vld          <= {vld[3:0], frame_valid};
      result_valid <= vld[4];
    end
  end

  logic signed [15:0] value;

  sfd_scaler u_scaler (
    .clk   (clk),
    .en    (adv),
    .sel   (s1_sel),
    .prod  (s1_prod),
    .pir   (s1_pir),
    .value (value)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      result.status          <= side_pipe[4].status;
      result.sensor_kind     <= side_pipe[4].kind;
      result.switch_number   <= side_pipe[4].sw;
      result.converted_value <= value;
      result.load_request    <= side_pipe[4].req;
      result.load_target     <= side_pipe[4].target;
      result.load_event      <= side_pipe[4].evt;
    end
  end

  // error results carry no reading and no load request
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status != sfd_pkg::STATUS_OK) |->
      (result.converted_value == 16'sd0 && !result.load_request))
    else $error("error result carries data");

  // a load request only comes from an accepted touch transaction
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.load_request) |->
      (result.status == sfd_pkg::STATUS_OK && result.sensor_kind == sfd_pkg::KIND_TOUCH
       && result.converted_value == 16'sd0))
    else $error("load request on a non-touch result");

  // input is held back only by a waiting result
  assert property (@(posedge clk) disable iff (rst)
    frame_stall |-> result_valid)
    else $error("frame stalled with no pending result");

  // a stalled pipeline keeps its occupancy
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (vld == $past(vld)))
    else $error("pipeline moved during a stall");

endmodule

// ===== bench/testbench.sv =====
// testbench for sensor_frame_decoder: directed and random frames, with a behavioral
// decoder model that predicts every reading and checks it against the result channel.
// Depends on sfd_pkg and sensor_frame_decoder.
module testbench;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 12;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             frame_valid = 1'b0;
  logic             frame_stall;
  sfd_pkg::frame_t  frame_in = '0;
  logic             result_valid;
  logic             result_stall = 1'b0;
  sfd_pkg::result_t result_out;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [2:0]       cfg_data = '0;

  // model copy of the device type register
  logic [2:0]       accepted_type = sfd_pkg::DEV_TYPE_RESET;
  sfd_pkg::result_t pending_readings[$];
  int               fail_count = 0;
  int               cycle_count = 0;

  // idling controls, percent per cycle
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // long receiver hold-off requests
  int hold_len = 0;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;

  sensor_frame_decoder i_dut (
    .clk          (clk),
    .rst          (rst),
    .frame_valid  (frame_valid),
    .frame_stall  (frame_stall),
    .frame        (frame_in),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result_out),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // decoded reading for one frame under the given device type
  function automatic sfd_pkg::result_t decode_reading(sfd_pkg::frame_t f, logic [2:0] dev);
    sfd_pkg::result_t r;
    logic [7:0]       x;
    logic [3:0]       nib;
    logic [3:0]       kind;
    logic [9:0]       raw;
    int               celsius;
    r = '0;
    x = f.frame_byte0 ^ f.frame_byte1 ^ f.frame_byte2 ^ f.frame_byte3;
    nib = x[7:4] ^ x[3:0];
    kind = {f.frame_byte0[1:0], f.frame_byte1[7:6]};
    raw = {f.frame_byte1[5:0], f.frame_byte2[7:4]};
    r.sensor_kind = kind;
    r.switch_number = f.frame_byte0[4:2];
    if (nib != 4'd0) begin
      r.status = sfd_pkg::STATUS_BAD_CHECKSUM;
    end else if (f.frame_byte0[7:5] != dev) begin
      r.status = sfd_pkg::STATUS_WRONG_DEVICE;
    end else if (kind > sfd_pkg::KIND_TOUCH) begin
      r.status = sfd_pkg::STATUS_UNKNOWN_KIND;
    end else begin
      r.status = sfd_pkg::STATUS_OK;
      case (kind)
        sfd_pkg::KIND_TEMPERATURE: begin
          // integer division truncates toward zero
          celsius = (3226 * int'(raw) - 500000) / 10000;
          r.converted_value = 16'((9 * celsius + 160) / 5);
        end
        sfd_pkg::KIND_HUMIDITY: begin
          r.converted_value = 16'((3226 * int'(raw) - 750000) / 30000);
        end
        sfd_pkg::KIND_LIGHT: begin
          r.converted_value = 16'((25808 * int'(raw)) / 1000);
        end
        sfd_pkg::KIND_PIR: begin
          r.converted_value = {15'd0, f.frame_byte1[0]};
        end
        default: begin
          r.load_target = raw[9:7];
          r.load_event = raw[6:4];
          r.load_request = (raw[6:4] != sfd_pkg::EVT_NO_LOAD);
        end
      endcase
    end
    return r;
  endfunction

  // builds a frame whose checksum nibble makes the nibble xor zero
  function automatic sfd_pkg::frame_t build_frame(logic [2:0] dev, logic [2:0] sw,
                                                  logic [3:0] kind, logic [9:0] raw,
                                                  logic [3:0] spare2, logic [3:0] spare3);
    sfd_pkg::frame_t f;
    logic [7:0]      x;
    f.frame_byte0 = {dev, sw, kind[3:2]};
    f.frame_byte1 = {kind[1:0], raw[9:4]};
    f.frame_byte2 = {raw[3:0], spare2};
    f.frame_byte3 = {spare3, 4'd0};
    x = f.frame_byte0 ^ f.frame_byte1 ^ f.frame_byte2 ^ f.frame_byte3;
    f.frame_byte3[3:0] = x[7:4] ^ x[3:0];
    return f;
  endfunction

  // mostly well-formed frames, the rest broken in one way or pure noise
  function automatic sfd_pkg::frame_t random_frame(logic [2:0] dev);
    sfd_pkg::frame_t f;
    int              pick;
    pick = $urandom_range(99);
    f = build_frame(dev, 3'($urandom), 4'($urandom_range(0, 4)), 10'($urandom),
                    4'($urandom), 4'($urandom));
    if (pick >= 93) begin
      f = sfd_pkg::frame_t'($urandom);
    end else if (pick >= 86) begin
      f = build_frame(dev, 3'($urandom), 4'($urandom_range(5, 15)), 10'($urandom),
                      4'($urandom), 4'($urandom));
    end else if (pick >= 78) begin
      f = build_frame(dev ^ 3'($urandom_range(1, 7)), 3'($urandom),
                      4'($urandom_range(0, 15)), 10'($urandom), 4'($urandom), 4'($urandom));
    end else if (pick >= 70) begin
      f.frame_byte3[3:0] = f.frame_byte3[3:0] ^ 4'($urandom_range(1, 15));
    end
    return f;
  endfunction

  // offer one frame, record its reading at the transaction, then idle at random
  task automatic send_frame(sfd_pkg::frame_t f);
    int gap;
    gap = 0;
    frame_in <= f;
    frame_valid <= 1'b1;
    do @(posedge clk); while (frame_stall);
    pending_readings.push_back(decode_reading(f, accepted_type));
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      frame_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    frame_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_device_type(logic [2:0] value);
    wait_drained();
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    accepted_type = value;
  endtask

  task automatic run_random_phase(int count, int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    repeat (count) send_frame(random_frame(accepted_type));
  endtask

  task automatic test_directed();
    sfd_pkg::frame_t f;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    // temperature: both raw extremes, a negative truncation and a truncation to zero
    send_frame(build_frame(sfd_pkg::DEV_TYPE_RESET, 3'd0, sfd_pkg::KIND_TEMPERATURE, 10'd0,
                           4'h0, 4'h0));
    send_frame(build_frame(sfd_pkg::DEV_TYPE_RESET, 3'd7, sfd_pkg::KIND_TEMPERATURE,
                           10'd1023, 4'hF, 4'hF));
    send_frame(build_frame(sfd_pkg::DEV_TYPE_RESET, 3'd2, sfd_pkg::KIND_TEMPERATURE,
                           10'd100, 4'h5, 4'hA));
    send_frame(build_frame(sfd_pkg::DEV_TYPE_RESET, 3'd5, sfd_pkg::KIND_TEMPERATURE,
                           10'd154, 4'hA, 4'h5));
    send_frame(build_frame(sfd_pkg::DEV_TYPE_RESET, 3'd0, sfd_pkg::KIND_HUMIDITY, 10'd0,
                           4'h0, 4'h0));
    send_frame(build_frame(sfd_pkg::DEV_TYPE_RESET, 3'd7, sfd_pkg::KIND_HUMIDITY, 10'd1023,
                           4'h0, 4'h0));
    send_frame(build_frame(sfd_pkg::DEV_TYPE_RESET, 3'd1, sfd_pkg::KIND_HUMIDITY, 10'd200,
                           4'h3, 4'hC));
    send_frame(build_frame(sfd_pkg::DEV_TYPE_RESET, 3'd0, sfd_pkg::KIND_LIGHT, 10'd0,
                           4'h0, 4'h0));
    send_frame(build_frame(sfd_pkg::DEV_TYPE_RESET, 3'd7, sfd_pkg::KIND_LIGHT, 10'd1023,
                           4'hF, 4'hF));
    // pir bit is byte1 bit 0, i.e. raw bit 4
    send_frame(build_frame(sfd_pkg::DEV_TYPE_RESET, 3'd3, sfd_pkg::KIND_PIR, 10'h010,
                           4'h0, 4'h0));
    send_frame(build_frame(sfd_pkg::DEV_TYPE_RESET, 3'd4, sfd_pkg::KIND_PIR, 10'h3EF,
                           4'hF, 4'hF));
    // touch: the no-load event, event zero and event seven
    send_frame(build_frame(sfd_pkg::DEV_TYPE_RESET, 3'd6, sfd_pkg::KIND_TOUCH,
                           {3'd7, sfd_pkg::EVT_NO_LOAD, 4'hF}, 4'h0, 4'h0));
    send_frame(build_frame(sfd_pkg::DEV_TYPE_RESET, 3'd0, sfd_pkg::KIND_TOUCH, 10'd0,
                           4'h0, 4'h0));
    send_frame(build_frame(sfd_pkg::DEV_TYPE_RESET, 3'd7, sfd_pkg::KIND_TOUCH,
                           {3'd5, 3'd7, 4'h0}, 4'hF, 4'hF));
    send_frame(build_frame(sfd_pkg::DEV_TYPE_RESET, 3'd1, 4'd5, 10'd512, 4'h0, 4'h0));
    send_frame(build_frame(sfd_pkg::DEV_TYPE_RESET, 3'd2, 4'd15, 10'd1023, 4'hF, 4'hF));
    send_frame(build_frame(3'd0, 3'd0, sfd_pkg::KIND_TEMPERATURE, 10'd300, 4'h0, 4'h0));
    // device type is checked before kind
    send_frame(build_frame(3'd7, 3'd7, 4'd15, 10'd300, 4'h0, 4'h0));
    f = build_frame(sfd_pkg::DEV_TYPE_RESET, 3'd3, sfd_pkg::KIND_LIGHT, 10'd700, 4'h0, 4'h0);
    f.frame_byte3 = f.frame_byte3 ^ 8'h01;
    send_frame(f);
    // checksum is checked before device type and kind
    f = build_frame(3'd6, 3'd3, 4'd12, 10'd700, 4'h0, 4'h0);
    f.frame_byte3 = f.frame_byte3 ^ 8'h08;
    send_frame(f);
    send_frame('0);
    send_frame('1);
  endtask

  task automatic test_device_type_extremes();
    write_device_type(3'd0);
    run_random_phase(15, 30, 30);
    write_device_type(3'd7);
    run_random_phase(15, 30, 30);
  endtask

  task automatic test_random_no_idle();
    write_device_type(3'($urandom));
    run_random_phase(130, 0, 0);
  endtask

  task automatic test_random_sender_idle();
    write_device_type(3'($urandom));
    run_random_phase(130, 82, 0);
  endtask

  task automatic test_random_receiver_stall();
    write_device_type(3'($urandom));
    run_random_phase(130, 0, 82);
  endtask

  task automatic test_random_both_idle();
    write_device_type(sfd_pkg::DEV_TYPE_RESET);
    run_random_phase(130, 12, 12);
  endtask

  task automatic test_backpressure();
    write_device_type(3'd5);
    hold_len = 300;
    hold_seq = hold_seq + 1;
    run_random_phase(40, 0, 0);
    // sender pauses until the pipeline is empty, then resumes
    wait_drained();
    run_random_phase(20, 0, 40);
  endtask

  // result sink: random stall plus the occasional long hold-off
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= hold_len;
      result_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    sfd_pkg::result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_readings.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, result_out);
        fail_count++;
      end else begin
        want = pending_readings.pop_front();
        check_field("status", want.status, result_out.status);
        check_field("sensor_kind", want.sensor_kind, result_out.sensor_kind);
        check_field("switch_number", want.switch_number, result_out.switch_number);
        check_field("converted_value", want.converted_value, result_out.converted_value);
        check_field("load_request", want.load_request, result_out.load_request);
        check_field("load_target", want.load_target, result_out.load_target);
        check_field("load_event", want.load_event, result_out.load_event);
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_device_type_extremes();
    test_random_no_idle();
    test_random_sender_idle();
    test_random_receiver_stall();
    test_random_both_idle();
    test_backpressure();
    wait_drained();
    if (fail_count == 0 && pending_readings.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
